### rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types and codes for the Modbus RTU slave responder.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  // default store depths and frame limit
  localparam int COIL_DEPTH_DEF      = 1024;
  localparam int REG_DEPTH_DEF       = 256;
  localparam int MAX_FRAME_BYTES_DEF = 64;

  // width of a store size or an address sum (depth up to 65536)
  localparam int SIZE_W = 17;

  // request actions
  localparam logic [3:0] ACT_RD_COILS    = 4'd0;
  localparam logic [3:0] ACT_RD_DISCRETE = 4'd1;
  localparam logic [3:0] ACT_RD_HOLDING  = 4'd2;
  localparam logic [3:0] ACT_RD_INPUT    = 4'd3;
  localparam logic [3:0] ACT_WR_COIL     = 4'd4;
  localparam logic [3:0] ACT_WR_REG      = 4'd5;
  localparam logic [3:0] ACT_WR_COILS    = 4'd6;
  localparam logic [3:0] ACT_WR_REGS     = 4'd7;
  localparam logic [3:0] ACT_EXCEPTION   = 4'd8;
  localparam logic [3:0] ACT_LD_DISCRETE = 4'd9;
  localparam logic [3:0] ACT_LD_INREG    = 4'd10;

  // function codes of echo frames
  localparam logic [7:0] FC_WR_COIL  = 8'd5;
  localparam logic [7:0] FC_WR_REG   = 8'd6;
  localparam logic [7:0] FC_WR_COILS = 8'd15;
  localparam logic [7:0] FC_WR_REGS  = 8'd16;

  localparam logic [7:0]  EXC_FLAG  = 8'h80;
  localparam logic [15:0] COIL_ON   = 16'hFF00;
  localparam logic [15:0] COIL_OFF  = 16'h0000;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_REG_COUNT = 3'd4;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] element_index;
    logic [15:0] value;
    logic        element_last;
    logic [7:0]  function_code;
    logic [7:0]  exception_code;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       status;
  } rsp_t;

endpackage

### rtl/mbrtu_ram.sv
// ----------------------------------------------------------------------------
// mbrtu_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mbrtu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/modbus_rtu_slave_responder.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_responder
// Modbus RTU slave data model and response framer with CRC-16.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | direction | moves
//  --------+-------------------------------+-----------+--------------------------
//  req     | req_valid, req_ready, req     | in        | one request per handshake
//  rsp     | rsp_valid, rsp_ready, rsp     | out       | one frame byte or reject
//  cfg     | cfg_valid, cfg_ready,         | in        | register index and data
//          | cfg_index, cfg_data           |           |
//
//  after reset a clearing pass zeroes all four stores, one address per cycle; cfg writes
//  are taken then; a request is accepted in S_IDLE and decoded in S_DECODE; each body
//  byte then takes setup, one crc shift per bit and the output register, plus a read
//  and capture per word fetch or per bit of a packed coil byte; each crc byte takes a
//  setup and the output register
//  a request is taken only when the previous one is fully delivered; rsp stalls hold
//  the output register and the sequencer
// ----------------------------------------------------------------------------
module modbus_rtu_slave_responder
  import mbrtu_pkg::*;
#(
  parameter int COIL_DEPTH      = COIL_DEPTH_DEF,
  parameter int REG_DEPTH       = REG_DEPTH_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int CAW       = $clog2(COIL_DEPTH);
  localparam int RAW       = $clog2(REG_DEPTH);
  localparam int CLR_DEPTH = (COIL_DEPTH > REG_DEPTH) ? COIL_DEPTH : REG_DEPTH;
  localparam int CLW       = $clog2(CLR_DEPTH);
  localparam int KW        = $clog2(MAX_FRAME_BYTES + 2);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_BYTE, S_BIT_RD, S_BIT_CAP,
    S_WORD_RD, S_WORD_CAP, S_CRC, S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [7:0]  device_address;
  logic [10:0] coil_count;
  logic [10:0] discrete_count;
  logic [8:0]  holding_count;
  logic [8:0]  input_reg_count;

  // request and sequencer registers
  req_t            r;
  logic [KW-1:0]   k;          // frame byte position
  logic [KW-1:0]   body_len;   // bytes before the crc
  logic [7:0]      nbytes;     // read byte count field
  logic [15:0]     crc;
  logic [2:0]      bitc;       // crc shift count and coil bit position
  logic [15:0]     elem_cnt;   // elements fetched so far in a read
  logic [7:0]      acc;
  logic [15:0]     word;
  logic [7:0]      cur_byte;
  logic [CLW-1:0]  clr_cnt;

  // store limits
  logic [SIZE_W-1:0] csz, dsz, hsz, isz;
  assign csz = (32'(coil_count) < COIL_DEPTH) ? SIZE_W'(coil_count) : SIZE_W'(COIL_DEPTH);
  assign dsz = (32'(discrete_count) < COIL_DEPTH) ? SIZE_W'(discrete_count)
                                                  : SIZE_W'(COIL_DEPTH);
  assign hsz = (32'(holding_count) < REG_DEPTH) ? SIZE_W'(holding_count)
                                                : SIZE_W'(REG_DEPTH);
  assign isz = (32'(input_reg_count) < REG_DEPTH) ? SIZE_W'(input_reg_count)
                                                  : SIZE_W'(REG_DEPTH);

  // request decode, from the captured request
  logic [SIZE_W-1:0] sz, qty_x, start_x, wr_addr;
  logic [SIZE_W:0]   coil_nb, reg_nb;
  logic              rng_ok, elem_ok, coil_fit, reg_fit;
  logic              req_ok, has_frame, is_multi;
  logic [KW-1:0]     body_len_d;
  logic [7:0]        nbytes_d;

  assign start_x = SIZE_W'(r.start_address);
  assign coil_nb = ((SIZE_W+1)'(r.quantity) + (SIZE_W+1)'(7)) >> 3;
  assign reg_nb  = (SIZE_W+1)'({r.quantity, 1'b0});
  assign coil_fit = (32'(coil_nb) + 32'd5) <= MAX_FRAME_BYTES;
  assign reg_fit  = (32'(reg_nb) + 32'd5) <= MAX_FRAME_BYTES;
  assign elem_ok  = r.element_index < r.quantity;
  assign is_multi = (r.action == ACT_WR_COILS) || (r.action == ACT_WR_REGS);
  assign wr_addr  = start_x + (is_multi ? SIZE_W'(r.element_index) : SIZE_W'(0));
  assign rng_ok   = (start_x < sz) && ((start_x + qty_x) <= sz);

  always_comb begin
    sz         = '0;
    qty_x      = SIZE_W'(r.quantity);
    req_ok     = 1'b0;
    has_frame  = 1'b0;
    body_len_d = KW'(3);
    nbytes_d   = 8'(reg_nb);
    case (r.action) inside
      ACT_RD_COILS, ACT_RD_DISCRETE: begin
        sz         = (r.action == ACT_RD_COILS) ? csz : dsz;
        req_ok     = rng_ok && coil_fit;
        has_frame  = 1'b1;
        nbytes_d   = 8'(coil_nb);
        body_len_d = KW'(coil_nb) + KW'(3);
      end
      ACT_RD_HOLDING, ACT_RD_INPUT: begin
        sz         = (r.action == ACT_RD_HOLDING) ? hsz : isz;
        req_ok     = rng_ok && reg_fit;
        has_frame  = 1'b1;
        body_len_d = KW'(reg_nb) + KW'(3);
      end
      ACT_WR_COIL, ACT_WR_REG: begin
        sz         = (r.action == ACT_WR_COIL) ? csz : hsz;
        qty_x      = '0;
        req_ok     = rng_ok;
        has_frame  = 1'b1;
        body_len_d = KW'(6);
      end
      ACT_WR_COILS, ACT_WR_REGS: begin
        sz         = (r.action == ACT_WR_COILS) ? csz : hsz;
        req_ok     = rng_ok && elem_ok;
        has_frame  = r.element_last;
        body_len_d = KW'(6);
      end
      ACT_EXCEPTION: begin
        req_ok    = 1'b1;
        has_frame = 1'b1;
      end
      ACT_LD_DISCRETE, ACT_LD_INREG: begin
        sz     = (r.action == ACT_LD_DISCRETE) ? dsz : isz;
        qty_x  = '0;
        req_ok = rng_ok;
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
  end

  // store access: clearing pass, or the write of a decoded request
  logic              wr_go, clearing;
  logic              coil_we, disc_we, hold_we, inp_we;
  logic [CAW-1:0]    c_waddr;
  logic [RAW-1:0]    r_waddr;
  logic              bit_wdata;
  logic [15:0]       word_wdata;
  logic [SIZE_W-1:0] rd_addr;
  logic              coil_q, disc_q;
  logic [15:0]       hold_q, inp_q;

  assign clearing  = (state == S_CLEAR);
  assign wr_go     = (state == S_DECODE) && req_ok;
  assign coil_we   = clearing ? (32'(clr_cnt) < COIL_DEPTH)
                              : wr_go && ((r.action == ACT_WR_COIL) || (r.action == ACT_WR_COILS));
  assign disc_we   = clearing ? (32'(clr_cnt) < COIL_DEPTH)
                              : wr_go && (r.action == ACT_LD_DISCRETE);
  assign hold_we   = clearing ? (32'(clr_cnt) < REG_DEPTH)
                              : wr_go && ((r.action == ACT_WR_REG) || (r.action == ACT_WR_REGS));
  assign inp_we    = clearing ? (32'(clr_cnt) < REG_DEPTH)
                              : wr_go && (r.action == ACT_LD_INREG);
  assign c_waddr   = clearing ? CAW'(clr_cnt) : wr_addr[CAW-1:0];
  assign r_waddr   = clearing ? RAW'(clr_cnt) : wr_addr[RAW-1:0];
  assign bit_wdata = clearing ? 1'b0 : (|r.value);
  assign word_wdata = clearing ? 16'h0000 : r.value;
  assign rd_addr   = start_x + SIZE_W'(elem_cnt);

  mbrtu_ram #(.WIDTH(1), .DEPTH(COIL_DEPTH)) u_coil (
    .clk, .we(coil_we), .waddr(c_waddr), .wdata(bit_wdata),
    .raddr(rd_addr[CAW-1:0]), .rdata(coil_q)
  );
  mbrtu_ram #(.WIDTH(1), .DEPTH(COIL_DEPTH)) u_disc (
    .clk, .we(disc_we), .waddr(c_waddr), .wdata(bit_wdata),
    .raddr(rd_addr[CAW-1:0]), .rdata(disc_q)
  );
  mbrtu_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_hold (
    .clk, .we(hold_we), .waddr(r_waddr), .wdata(word_wdata),
    .raddr(rd_addr[RAW-1:0]), .rdata(hold_q)
  );
  mbrtu_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_inp (
    .clk, .we(inp_we), .waddr(r_waddr), .wdata(word_wdata),
    .raddr(rd_addr[RAW-1:0]), .rdata(inp_q)
  );

  // next body byte at position k
  logic [7:0]  imm_byte, echo_code;
  logic [15:0] echo_val;
  logic        need_bits, need_word;
  logic        bit_q, bit_take;
  logic [15:0] word_q;
  logic [7:0]  acc_next;
  logic [15:0] crc_shift;

  assign bit_q    = (r.action == ACT_RD_COILS) ? coil_q : disc_q;
  assign word_q   = (r.action == ACT_RD_HOLDING) ? hold_q : inp_q;
  assign bit_take = elem_cnt < r.quantity;
  assign crc_shift = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);

  always_comb begin
    acc_next       = acc;
    acc_next[bitc] = bit_take ? bit_q : 1'b0;
  end

  always_comb begin
    echo_code = FC_WR_COIL;
    echo_val  = r.quantity;
    case (r.action)
      ACT_WR_COIL: begin
        echo_code = FC_WR_COIL;
        echo_val  = (|r.value) ? COIL_ON : COIL_OFF;
      end
      ACT_WR_REG: begin
        echo_code = FC_WR_REG;
        echo_val  = r.value;
      end
      ACT_WR_COILS: echo_code = FC_WR_COILS;
      default:      echo_code = FC_WR_REGS;
    endcase
  end

  always_comb begin
    imm_byte  = '0;
    need_bits = 1'b0;
    need_word = 1'b0;
    if (k == KW'(0)) begin
      imm_byte = device_address;
    end else begin
      case (r.action) inside
        ACT_RD_COILS, ACT_RD_DISCRETE, ACT_RD_HOLDING, ACT_RD_INPUT: begin
          if (k == KW'(1)) begin
            imm_byte = 8'(r.action) + 8'd1;
          end else if (k == KW'(2)) begin
            imm_byte = nbytes;
          end else if ((r.action == ACT_RD_COILS) || (r.action == ACT_RD_DISCRETE)) begin
            need_bits = 1'b1;
          end else if (k[0]) begin
            need_word = 1'b1;   // high byte fetches the word
          end else begin
            imm_byte = word[7:0];
          end
        end
        ACT_EXCEPTION: begin
          imm_byte = (k == KW'(1)) ? (r.function_code + EXC_FLAG) : r.exception_code;
        end
        default: begin
          case (k)
            KW'(1):  imm_byte = echo_code;
            KW'(2):  imm_byte = r.start_address[15:8];
            KW'(3):  imm_byte = r.start_address[7:0];
            KW'(4):  imm_byte = echo_val[15:8];
            default: imm_byte = echo_val[7:0];
          endcase
        end
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_cnt         <= '0;
      rsp_valid       <= 1'b0;
      device_address  <= 8'd1;
      coil_count      <= '0;
      discrete_count  <= '0;
      holding_count   <= '0;
      input_reg_count <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DEVICE_ADDRESS:  device_address  <= cfg_data[7:0];
          CFG_COIL_COUNT:      coil_count      <= cfg_data[10:0];
          CFG_DISCRETE_COUNT:  discrete_count  <= cfg_data[10:0];
          CFG_HOLDING_COUNT:   holding_count   <= cfg_data[8:0];
          CFG_INPUT_REG_COUNT: input_reg_count <= cfg_data[8:0];
          default: ;
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CLW'(1);
          if (32'(clr_cnt) == CLR_DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            r     <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          k        <= '0;
          crc      <= CRC_INIT;
          elem_cnt <= '0;
          body_len <= body_len_d;
          nbytes   <= nbytes_d;
          if (!req_ok) begin
            rsp       <= '{frame_byte: 8'h00, frame_last: 1'b1, status: 1'b1};
            rsp_valid <= 1'b1;
            state     <= S_EMIT;
          end else if (has_frame) begin
            state <= S_BYTE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_BYTE: begin
          bitc <= '0;
          acc  <= '0;
          if (k < body_len) begin
            if (need_bits) begin
              state <= S_BIT_RD;
            end else if (need_word) begin
              state <= S_WORD_RD;
            end else begin
              cur_byte <= imm_byte;
              crc      <= crc ^ {8'h00, imm_byte};
              state    <= S_CRC;
            end
          end else begin
            // crc trailer, low byte first
            rsp.frame_byte <= (k == body_len) ? crc[7:0] : crc[15:8];
            rsp.frame_last <= (k != body_len);
            rsp.status     <= 1'b0;
            rsp_valid      <= 1'b1;
            state          <= S_EMIT;
          end
        end
        S_BIT_RD: state <= S_BIT_CAP;
        S_BIT_CAP: begin
          acc  <= acc_next;
          bitc <= bitc + 3'd1;
          if (bit_take) begin
            elem_cnt <= elem_cnt + 16'd1;
          end
          if (bitc == 3'd7) begin
            cur_byte <= acc_next;
            crc      <= crc ^ {8'h00, acc_next};
            state    <= S_CRC;
          end else begin
            state <= S_BIT_RD;
          end
        end
        S_WORD_RD: state <= S_WORD_CAP;
        S_WORD_CAP: begin
          word     <= word_q;
          cur_byte <= word_q[15:8];
          crc      <= crc ^ {8'h00, word_q[15:8]};
          elem_cnt <= elem_cnt + 16'd1;
          state    <= S_CRC;
        end
        S_CRC: begin
          crc  <= crc_shift;
          bitc <= bitc + 3'd1;
          if (bitc == 3'd7) begin
            rsp       <= '{frame_byte: cur_byte, frame_last: 1'b0, status: 1'b0};
            rsp_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            k         <= k + KW'(1);
            state     <= rsp.frame_last ? S_IDLE : S_BYTE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while a response byte is pending");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken before the first was decoded");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status) |-> (rsp.frame_last && (rsp.frame_byte == 8'h00)))
    else $error("malformed reject item");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_BYTE) |-> (k <= body_len + KW'(1)))
    else $error("frame position ran past the crc trailer");
`endif

endmodule
